// ===== rtl/bphd_pkg.sv =====
// ----------------------------------------------------------------------------
// bphd_pkg
// Shared types, constants and helpers of the button press and hold detector.
// ----------------------------------------------------------------------------
package bphd_pkg;

  localparam int COUNT_BITS = 8;
  localparam int RC_W       = COUNT_BITS + 1;
  localparam int VAL_W      = COUNT_BITS + 2;
  localparam int ELAPSED_W  = 17;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int VALUE_W    = 9;
  localparam int VALUE_MAX  = 255;

  localparam logic signed [RC_W-1:0] CNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BOUNCE,
    PH_DOWN,
    PH_UP
  } bphd_phase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_PRESSED,
    EV_HELD,
    EV_RELEASED
  } bphd_kind_t;

  typedef struct packed {
    bphd_kind_t                 kind;
    logic signed [VALUE_W-1:0]  value;
    logic                       down;
    logic                       last;
  } bphd_result_t;

  function automatic logic signed [VALUE_W-1:0] clamp_value(
    input logic signed [VAL_W-1:0] v
  );
    logic signed [VALUE_W-1:0] r;
    if (v > VALUE_MAX) begin
      r = VALUE_W'(VALUE_MAX);
    end else if (v < -VALUE_MAX) begin
      r = VALUE_W'(-VALUE_MAX);
    end else begin
      r = VALUE_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/bphd_core.sv =====
// ----------------------------------------------------------------------------
// bphd_core
// Configuration registers, phase machine and counters; forms the one or two
// result words of each accepted input word.
// ----------------------------------------------------------------------------
module bphd_core
  import bphd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata,
  input  logic                 accept,
  input  logic                 tick,
  input  logic                 level,
  output bphd_result_t         res0,
  output bphd_result_t         res1,
  output logic                 res_two
);

  logic                   pressed_level_r;
  logic [TICK_W-1:0]      debounce_ticks_r;
  logic [TICK_W-1:0]      gap_ticks_r;
  logic [TICK_W-1:0]      hold_ticks_r;

  bphd_phase_t            phase_r, phase_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [COUNT_BITS-1:0]  press_r, press_nxt;
  logic signed [RC_W-1:0] rel_r, rel_nxt;
  logic [COUNT_BITS-1:0]  hold_r, hold_nxt;

  logic [ELAPSED_W-1:0]   elapsed_inc;
  logic                   exp_deb, exp_gap, exp_hold, match, click_ok;
  logic [COUNT_BITS-1:0]  press_inc, hold_inc;
  logic signed [RC_W-1:0] rel_inc;
  logic signed [VALUE_W-1:0] click_val, held_val, rel_val;
  bphd_kind_t             kind0, kind1;
  logic signed [VALUE_W-1:0] val0, val1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r  <= 1'b0;
      debounce_ticks_r <= TICK_W'(20);
      gap_ticks_r      <= TICK_W'(300);
      hold_ticks_r     <= TICK_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESSED_LEVEL:  pressed_level_r  <= cfg_wdata[0];
        CFG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata;
        CFG_GAP_TICKS:      gap_ticks_r      <= cfg_wdata;
        CFG_HOLD_TICKS:     hold_ticks_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + ELAPSED_W'(1);
  assign exp_deb     = elapsed_inc > {1'b0, debounce_ticks_r};
  assign exp_gap     = elapsed_inc > {1'b0, gap_ticks_r};
  assign exp_hold    = elapsed_inc > {1'b0, hold_ticks_r};
  assign match       = level == pressed_level_r;
  assign click_ok    = !rel_r[RC_W-1] && (rel_r != '0);
  assign press_inc   = (&press_r) ? press_r : press_r + COUNT_BITS'(1);
  assign hold_inc    = (&hold_r) ? hold_r : hold_r + COUNT_BITS'(1);
  assign rel_inc     = (rel_r >= CNT_MAX) ? CNT_MAX : rel_r + RC_W'(1);
  assign click_val   = clamp_value({rel_r[RC_W-1], rel_r} - VAL_W'(1));
  assign held_val    = clamp_value($signed({2'b00, hold_r}));
  assign rel_val     = clamp_value(-$signed({2'b00, hold_r}));

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (!tick) begin
            phase_nxt   = PH_BOUNCE;
            elapsed_nxt = '0;
          end
        end
        PH_BOUNCE: begin
          if (tick) begin
            elapsed_nxt = elapsed_inc;
            if (exp_deb) begin
              phase_nxt   = match ? PH_DOWN : PH_UP;
              elapsed_nxt = '0;
            end
          end
        end
        PH_DOWN: begin
          if (tick) begin
            elapsed_nxt = exp_hold ? elapsed_inc - {1'b0, hold_ticks_r} : elapsed_inc;
          end else begin
            phase_nxt   = PH_BOUNCE;
            elapsed_nxt = '0;
          end
        end
        PH_UP: begin
          if (tick) begin
            elapsed_nxt = elapsed_inc;
            if (exp_gap) begin
              phase_nxt   = PH_IDLE;
              elapsed_nxt = '0;
            end
          end else begin
            phase_nxt   = PH_BOUNCE;
            elapsed_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    press_nxt = press_r;
    rel_nxt   = rel_r;
    hold_nxt  = hold_r;
    kind0     = EV_NONE;
    val0      = '0;
    kind1     = EV_NONE;
    val1      = '0;
    res_two   = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_BOUNCE: begin
          if (tick && exp_deb) begin
            if (match) begin
              rel_nxt   = $signed({1'b0, press_r});
              press_nxt = press_inc;
            end else begin
              rel_nxt   = rel_inc;
              press_nxt = rel_inc[COUNT_BITS-1:0];
            end
          end
        end
        PH_DOWN: begin
          if (tick) begin
            if (exp_gap && click_ok) begin
              kind0     = EV_PRESSED;
              val0      = click_val;
              rel_nxt   = '0;
              press_nxt = '0;
            end
            if (exp_hold) begin
              hold_nxt = hold_inc;
              if (exp_gap && click_ok) begin
                kind1   = EV_HELD;
                val1    = held_val;
                res_two = 1'b1;
              end else begin
                kind0 = EV_HELD;
                val0  = held_val;
              end
            end
          end else if (hold_r != '0) begin
            kind0     = EV_RELEASED;
            val0      = rel_val;
            hold_nxt  = '0;
            press_nxt = '0;
            rel_nxt   = '1;
          end
        end
        PH_UP: begin
          if (tick && exp_gap && click_ok) begin
            kind0     = EV_PRESSED;
            val0      = click_val;
            rel_nxt   = '0;
            press_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign res0.kind  = kind0;
  assign res0.value = val0;
  assign res0.down  = phase_nxt == PH_DOWN;
  assign res0.last  = !res_two;
  assign res1.kind  = kind1;
  assign res1.value = val1;
  assign res1.down  = phase_nxt == PH_DOWN;
  assign res1.last  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      press_r   <= '0;
      rel_r     <= '0;
      hold_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      press_r   <= press_nxt;
      rel_r     <= rel_nxt;
      hold_r    <= hold_nxt;
    end
  end

  a_hold_only_down: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r != '0) |-> (phase_r == PH_DOWN))
    else $error("Held count is non-zero outside the down phase.");

  a_rel_neg_bounce: assert property (@(posedge clk) disable iff (!rst_n)
    rel_r[RC_W-1] |-> (phase_r == PH_BOUNCE && press_r == '0))
    else $error("Negative release count outside the bounce phase.");

  a_two_down_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res_two |-> (accept && tick && phase_r == PH_DOWN && phase_nxt == PH_DOWN))
    else $error("Two results outside a down-phase tick.");

endmodule

// ===== rtl/bphd_fifo.sv =====
// ----------------------------------------------------------------------------
// bphd_fifo
// Four-word result queue; takes one or two words per push and hands them
// out one at a time.
// ----------------------------------------------------------------------------
module bphd_fifo
  import bphd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic         push_two,
  input  bphd_result_t wr0,
  input  bphd_result_t wr1,
  output logic         room_two,
  output logic         rd_valid,
  input  logic         rd_ready,
  output bphd_result_t rd_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  bphd_result_t        mem [DEPTH];
  logic [PTR_W-1:0]    wp_r, rp_r;
  logic [PTR_W:0]      cnt_r, cnt_nxt;
  logic [PTR_W:0]      n_push;
  logic                pop;

  assign pop      = rd_valid && rd_ready;
  assign n_push   = push ? (push_two ? (PTR_W+1)'(2) : (PTR_W+1)'(1)) : '0;
  assign cnt_nxt  = cnt_r + n_push - (PTR_W+1)'(pop);
  assign room_two = cnt_r <= (PTR_W+1)'(DEPTH - 2);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr0;
      if (push_two) begin
        mem[wp_r + PTR_W'(1)] <= wr1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_push[PTR_W-1:0];
      rp_r  <= rp_r + PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(DEPTH))
    else $error("Result queue holds more words than it has.");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room_two)
    else $error("Push into a result queue without room for two words.");

endmodule

// ===== rtl/button_press_hold_detector.sv =====
// ----------------------------------------------------------------------------
// button_press_hold_detector
// Debounces a push button from pin-change and tick words and reports
// presses with their click count, held intervals and release after hold.
//
//   Channel | Ports                          | Word
//   in      | in_tvalid/tready/tdata/tuser   | tuser mode, tdata pin_level
//   out     | out_tvalid/tready/tdata/tuser  | tuser kind, tdata value, down
//   cfg     | cfg_we/cfg_index/cfg_wdata     | one register per write
//
// An input word is taken in every cycle while the result queue has room for
// two words; its results are in the queue from the next cycle.
// A word that causes two results gives two output words, the second with tlast.
// The output stalls only the queue; input stalls when fewer than two
// entries are free.
// Synchronous active-low reset restores the register defaults, idle phase
// and an empty queue.
// ----------------------------------------------------------------------------
module button_press_hold_detector
  import bphd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] pin_level, zero fill above
  input  logic                 in_tuser,   // [0] mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [8:0] event_value, [9] button_down
  output logic [1:0]           out_tuser,  // [1:0] event_kind
  output logic                 out_tlast
);

  logic         accept;
  logic         res_two;
  bphd_result_t res0, res1, rd_data;

  assign accept = in_tvalid && in_tready;

  bphd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .tick      (in_tuser),
    .level     (in_tdata[0]),
    .res0      (res0),
    .res1      (res1),
    .res_two   (res_two)
  );

  bphd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_two (res_two),
    .wr0      (res0),
    .wr1      (res1),
    .room_two (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (rd_data)
  );

  assign out_tdata = {6'd0, rd_data.down, rd_data.value};
  assign out_tuser = rd_data.kind;
  assign out_tlast = rd_data.last;

endmodule
